// ===== src/log_record_deframer_crc32c_top_defines.svh =====
// ----------------------------------------------------------------------------
// Log record deframer assertion macros
// Concurrent assertion wrappers clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_DEFRAMER_CRC32C_TOP_DEFINES_SVH
`define LOG_RECORD_DEFRAMER_CRC32C_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define LRD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("log record deframer assertion failed");
`define LRD_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("log record deframer assertion failed");
`else
`define LRD_ASSERT(lbl, prop)
`define LRD_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== src/lrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Log record deframer package
// Phase, kind and status codes, result types and the bytewise CRC32C.
// ----------------------------------------------------------------------------
package lrd_pkg;

	localparam logic [3:0] PH_SIZE  = 4'd0;
	localparam logic [3:0] PH_CRC   = 4'd1;
	localparam logic [3:0] PH_SEQ   = 4'd2;
	localparam logic [3:0] PH_EP    = 4'd3;
	localparam logic [3:0] PH_TAB   = 4'd4;
	localparam logic [3:0] PH_OP    = 4'd5;
	localparam logic [3:0] PH_VER   = 4'd6;
	localparam logic [3:0] PH_TIME  = 4'd7;
	localparam logic [3:0] PH_SLEN  = 4'd8;
	localparam logic [3:0] PH_SBODY = 4'd9;
	localparam logic [3:0] PH_TRAIL = 4'd10;

	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_VERDICT = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_TRUNC     = 3'd1;
	localparam logic [2:0] ST_SHORT     = 3'd2;
	localparam logic [2:0] ST_CRC       = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;

	localparam logic        CFG_CHECKSUM_ENABLE = 1'b0;
	localparam logic        CFG_LOG_LENGTH      = 1'b1;

	localparam logic [31:0] CRC_POLY = 32'h82F63B78;
	localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  string_index;
		logic [7:0]  byte_value;
		logic [63:0] record_seq;
		logic [63:0] endpoint_number;
		logic [63:0] table_number;
		logic [7:0]  operation;
		logic [63:0] version_number;
		logic [63:0] timestamp_us;
		logic [2:0]  status;
		logic [63:0] highest_seq;
	} result_t;

	typedef struct packed {
		logic [2:0] vld;
		result_t    r0;
		result_t    r1;
		result_t    r2;
	} step_out_t;

	typedef struct packed {
		logic [2:0] count;
		logic       room;
	} fifo_status_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// ===== src/lrd_core.sv =====
// ----------------------------------------------------------------------------
// Log record deframer core
// Record state and the per-byte parse step producing up to three results.
// ----------------------------------------------------------------------------
module lrd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [7:0]         data,
	input  logic               checksum_enable,
	input  logic [47:0]        log_length,
	output lrd_pkg::step_out_t res,
	output logic               stopped
);

	logic [3:0]  phase_q, n_phase;
	logic [3:0]  fbc_q, n_fbc;
	logic [31:0] rbc_q, n_rbc;
	logic [31:0] total_q, n_total;
	logic [31:0] hcrc_q, n_hcrc;
	logic [31:0] crc_q, n_crc;
	logic [63:0] seq_q, n_seq;
	logic [63:0] ep_q, n_ep;
	logic [63:0] tab_q, n_tab;
	logic [7:0]  op_q, n_op;
	logic [63:0] ver_q, n_ver;
	logic [63:0] ts_q, n_ts;
	logic [31:0] srem_q, n_srem;
	logic [1:0]  cur_q, n_cur;
	logic [47:0] seen_q, n_seen;
	logic        stop_q, n_stop;
	logic [63:0] high_q, n_high;

	logic        rem_zero, lt8, rem_zero2, lt82, at_start, do_verdict, mal, crc_bad;
	logic [47:0] diff, diff2;
	logic [48:0] reach;
	logic [2:0]  vstat;

	always_comb begin
		n_phase = phase_q; n_fbc = fbc_q; n_rbc = rbc_q; n_total = total_q;
		n_hcrc = hcrc_q; n_crc = crc_q; n_seq = seq_q; n_ep = ep_q; n_tab = tab_q;
		n_op = op_q; n_ver = ver_q; n_ts = ts_q; n_srem = srem_q; n_cur = cur_q;
		n_seen = seen_q; n_stop = stop_q; n_high = high_q;
		res = '0;
		do_verdict = 1'b0;
		mal = 1'b0;
		crc_bad = 1'b0;
		vstat = lrd_pkg::ST_OK;
		diff = log_length - seen_q;
		rem_zero = seen_q >= log_length;
		lt8 = rem_zero || (diff < 48'd8);
		at_start = (phase_q == lrd_pkg::PH_SIZE) && (fbc_q == 4'd0);
		reach = '0;
		diff2 = '0;
		rem_zero2 = 1'b0;
		lt82 = 1'b0;
		if (go && !stop_q) begin
			if (at_start && lt8) begin
				res.vld[2] = 1'b1;
				res.r2.kind = lrd_pkg::KIND_END;
				res.r2.status = rem_zero ? lrd_pkg::ST_OK : lrd_pkg::ST_TRUNC;
				res.r2.highest_seq = high_q;
				n_stop = 1'b1;
			end else if (!at_start && rem_zero) begin
				res.vld[2] = 1'b1;
				res.r2.kind = lrd_pkg::KIND_END;
				res.r2.status = lrd_pkg::ST_TRUNC;
				res.r2.highest_seq = high_q;
				n_stop = 1'b1;
			end else begin
				n_seen = seen_q + 48'd1;
				n_rbc = rbc_q + 32'd1;
				if (phase_q == lrd_pkg::PH_SIZE || phase_q == lrd_pkg::PH_CRC) begin
					if (phase_q == lrd_pkg::PH_SIZE)
						n_total[{fbc_q[1:0], 3'b000} +: 8] = data;
					else
						n_hcrc[{fbc_q[1:0], 3'b000} +: 8] = data;
					n_fbc = fbc_q + 4'd1;
					if (n_fbc == 4'd4) begin
						n_fbc = 4'd0;
						if (phase_q == lrd_pkg::PH_SIZE) begin
							n_phase = lrd_pkg::PH_CRC;
						end else begin
							n_phase = lrd_pkg::PH_SEQ;
							reach = {1'b0, n_seen} - 49'd8 + {17'd0, n_total};
							if (n_total < 32'd8) begin
								res.vld[2] = 1'b1;
								res.r2.kind = lrd_pkg::KIND_END;
								res.r2.status = lrd_pkg::ST_SHORT;
								res.r2.highest_seq = high_q;
								n_stop = 1'b1;
							end else if (reach > {1'b0, log_length}) begin
								res.vld[2] = 1'b1;
								res.r2.kind = lrd_pkg::KIND_END;
								res.r2.status = lrd_pkg::ST_TRUNC;
								res.r2.highest_seq = high_q;
								n_stop = 1'b1;
							end else if (n_total == 32'd8) begin
								do_verdict = 1'b1;
							end
						end
					end
				end else begin
					n_crc = lrd_pkg::crc_byte(crc_q, data);
					unique case (phase_q)
						lrd_pkg::PH_SEQ, lrd_pkg::PH_EP, lrd_pkg::PH_TAB,
						lrd_pkg::PH_VER, lrd_pkg::PH_TIME: begin
							unique case (phase_q)
								lrd_pkg::PH_SEQ: n_seq[{fbc_q[2:0], 3'b000} +: 8] = data;
								lrd_pkg::PH_EP:  n_ep[{fbc_q[2:0], 3'b000} +: 8] = data;
								lrd_pkg::PH_TAB: n_tab[{fbc_q[2:0], 3'b000} +: 8] = data;
								lrd_pkg::PH_VER: n_ver[{fbc_q[2:0], 3'b000} +: 8] = data;
								default:         n_ts[{fbc_q[2:0], 3'b000} +: 8] = data;
							endcase
							n_fbc = fbc_q + 4'd1;
							if (n_fbc == 4'd8) begin
								n_fbc = 4'd0;
								n_phase = phase_q + 4'd1;
							end
						end
						lrd_pkg::PH_OP: begin
							n_op = data;
							n_phase = lrd_pkg::PH_VER;
						end
						lrd_pkg::PH_SLEN: begin
							n_srem[{fbc_q[1:0], 3'b000} +: 8] = data;
							n_fbc = fbc_q + 4'd1;
							if (n_fbc == 4'd4) begin
								n_fbc = 4'd0;
								if (n_srem == 32'd0) begin
									if (cur_q >= 2'd2) begin
										n_phase = lrd_pkg::PH_TRAIL;
									end else begin
										n_cur = cur_q + 2'd1;
										n_phase = lrd_pkg::PH_SLEN;
										n_srem = 32'd0;
									end
								end else begin
									n_phase = lrd_pkg::PH_SBODY;
								end
							end
						end
						lrd_pkg::PH_SBODY: begin
							res.vld[0] = 1'b1;
							res.r0.kind = lrd_pkg::KIND_BYTE;
							res.r0.string_index = cur_q;
							res.r0.byte_value = data;
							res.r0.highest_seq = high_q;
							n_srem = srem_q - 32'd1;
							if (n_srem == 32'd0) begin
								if (cur_q >= 2'd2) begin
									n_phase = lrd_pkg::PH_TRAIL;
								end else begin
									n_cur = cur_q + 2'd1;
									n_phase = lrd_pkg::PH_SLEN;
									n_srem = 32'd0;
								end
							end
						end
						default: ;
					endcase
					do_verdict = (n_rbc == n_total);
				end
				if (do_verdict) begin
					mal = (n_phase != lrd_pkg::PH_TRAIL);
					crc_bad = checksum_enable && ((n_crc ^ lrd_pkg::ALL_ONES) != n_hcrc);
					if (crc_bad)
						vstat = lrd_pkg::ST_CRC;
					else if (mal)
						vstat = lrd_pkg::ST_MALFORMED;
					if (vstat == lrd_pkg::ST_OK && n_seq > high_q)
						n_high = n_seq;
					res.vld[1] = 1'b1;
					res.r1.kind = lrd_pkg::KIND_VERDICT;
					res.r1.record_seq = n_seq;
					res.r1.endpoint_number = n_ep;
					res.r1.table_number = n_tab;
					res.r1.operation = n_op;
					res.r1.version_number = n_ver;
					res.r1.timestamp_us = n_ts;
					res.r1.status = vstat;
					res.r1.highest_seq = n_high;
					diff2 = log_length - n_seen;
					rem_zero2 = n_seen >= log_length;
					lt82 = rem_zero2 || (diff2 < 48'd8);
					if (vstat != lrd_pkg::ST_OK) begin
						res.vld[2] = 1'b1;
						res.r2.kind = lrd_pkg::KIND_END;
						res.r2.status = vstat;
						res.r2.highest_seq = n_high;
						n_stop = 1'b1;
					end else begin
						n_phase = lrd_pkg::PH_SIZE; n_fbc = '0; n_rbc = '0; n_total = '0;
						n_hcrc = '0; n_crc = lrd_pkg::ALL_ONES; n_seq = '0; n_ep = '0;
						n_tab = '0; n_op = '0; n_ver = '0; n_ts = '0; n_srem = '0;
						n_cur = '0;
						if (lt82) begin
							res.vld[2] = 1'b1;
							res.r2.kind = lrd_pkg::KIND_END;
							res.r2.status = rem_zero2 ? lrd_pkg::ST_OK : lrd_pkg::ST_TRUNC;
							res.r2.highest_seq = n_high;
							n_stop = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lrd_pkg::PH_SIZE; fbc_q <= '0; rbc_q <= '0; total_q <= '0;
			hcrc_q <= '0; crc_q <= lrd_pkg::ALL_ONES; seq_q <= '0; ep_q <= '0;
			tab_q <= '0; op_q <= '0; ver_q <= '0; ts_q <= '0; srem_q <= '0;
			cur_q <= '0; seen_q <= '0; stop_q <= 1'b0; high_q <= '0;
		end else begin
			phase_q <= n_phase; fbc_q <= n_fbc; rbc_q <= n_rbc; total_q <= n_total;
			hcrc_q <= n_hcrc; crc_q <= n_crc; seq_q <= n_seq; ep_q <= n_ep;
			tab_q <= n_tab; op_q <= n_op; ver_q <= n_ver; ts_q <= n_ts;
			srem_q <= n_srem; cur_q <= n_cur; seen_q <= n_seen; stop_q <= n_stop;
			high_q <= n_high;
		end
	end

	assign stopped = stop_q;

endmodule

// ===== src/lrd_result_fifo.sv =====
// ----------------------------------------------------------------------------
// Log record deframer result queue
// Four-entry queue taking up to three results a cycle, one leaving per cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
module lrd_result_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrd_pkg::step_out_t    push,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lrd_pkg::result_t      head,
	output lrd_pkg::fifo_status_t st
);

	lrd_pkg::result_t q_q [4];
	logic [1:0] head_q, tail_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] npush;
	logic [1:0] w1, w2;

	assign out_valid = count_q != 3'd0;
	assign pop       = out_valid && !out_stall;
	assign head      = q_q[head_q];
	assign npush     = {1'b0, push.vld[0]} + {1'b0, push.vld[1]} + {1'b0, push.vld[2]};
	assign w1        = tail_q + {1'b0, push.vld[0]};
	assign w2        = w1 + {1'b0, push.vld[1]};
	assign st.count  = count_q;
	assign st.room   = (count_q - {2'b00, pop}) <= 3'd1;

	always_ff @(posedge clk) begin
		if (push.vld[0])
			q_q[tail_q] <= push.r0;
		if (push.vld[1])
			q_q[w1] <= push.r1;
		if (push.vld[2])
			q_q[w2] <= push.r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_q + {1'b0, pop};
			tail_q  <= tail_q + npush;
			count_q <= count_q + {1'b0, npush} - {2'b00, pop};
		end
	end

endmodule

// ===== src/log_record_deframer_crc32c_top.sv =====
// ----------------------------------------------------------------------------
// Log record deframer with CRC32C check
// Parses length-prefixed log records byte by byte and emits string bytes,
// record verdicts and the scan end status.
// ----------------------------------------------------------------------------
// Takes one log byte per cycle unless stalled: a byte is captured in an
// input register and parsed once the queue has room, when its results (at
// most three) land in a four-entry result queue, from which the first is
// offered. The input stalls only while the queue, after this cycle's
// departure, holds more than one result; a sink that never stalls sees one
// byte per cycle sustained. The user must write configuration only while no
// request is in flight; the block itself does not enforce it.
`include "log_record_deframer_crc32c_top_defines.svh"

module log_record_deframer_crc32c_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [1:0]  string_index,
	output logic [7:0]  byte_value,
	output logic [63:0] record_seq,
	output logic [63:0] endpoint_number,
	output logic [63:0] table_number,
	output logic [7:0]  operation,
	output logic [63:0] version_number,
	output logic signed [63:0] timestamp_us,
	output logic [2:0]  status,
	output logic [63:0] highest_seq
);

	logic                  csum_en_q;
	logic [47:0]           log_len_q;
	logic                  valid_s1;
	logic [7:0]            data_s1;
	logic                  go;
	logic                  stopped;
	lrd_pkg::step_out_t    step;
	lrd_pkg::result_t      head;
	lrd_pkg::fifo_status_t fst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csum_en_q <= 1'b1;
			log_len_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrd_pkg::CFG_CHECKSUM_ENABLE: csum_en_q <= cfg_data[0];
				lrd_pkg::CFG_LOG_LENGTH:      log_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign go       = valid_s1 && fst.room;
	assign in_stall = valid_s1 && !fst.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			data_s1 <= data_byte;
	end

	lrd_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.go              (go),
		.data            (data_s1),
		.checksum_enable (csum_en_q),
		.log_length      (log_len_q),
		.res             (step),
		.stopped         (stopped)
	);

	lrd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head),
		.st        (fst)
	);

	assign kind            = head.kind;
	assign string_index    = head.string_index;
	assign byte_value      = head.byte_value;
	assign record_seq      = head.record_seq;
	assign endpoint_number = head.endpoint_number;
	assign table_number    = head.table_number;
	assign operation       = head.operation;
	assign version_number  = head.version_number;
	assign timestamp_us    = head.timestamp_us;
	assign status          = head.status;
	assign highest_seq     = head.highest_seq;

	`LRD_ASSERT(a_fifo_bound, fst.count <= 3'd4)
	`LRD_ASSERT_NEXT(a_stop_sticky, stopped, stopped)
	`LRD_ASSERT(a_no_push_after_stop, !(stopped && step.vld != 3'd0))

endmodule
